// ----- rtl/fpc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package fpc_pkg;

    localparam int NUM_PLANES    = 6;
    localparam int PLANE_IDX_W   = 3;
    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_W        = 32;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_POINT  = 2'd1,
        KIND_SPHERE = 2'd2,
        KIND_BOX    = 2'd3
    } kind_t;

    // test beat travelling down the plane chain
    typedef struct packed {
        logic               valid;
        logic               pass;
        kind_t              kind;
        logic signed [31:0] x0;
        logic signed [31:0] y0;
        logic signed [31:0] z0;
        logic signed [31:0] r;
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic signed [31:0] z1;
    } probe_t;

    // plane write from the extraction unit
    typedef struct packed {
        logic                   en;
        logic [PLANE_IDX_W-1:0] idx;
        logic signed [31:0]     nx;
        logic signed [31:0]     ny;
        logic signed [31:0]     nz;
        logic signed [31:0]     d;
    } plane_wr_t;

endpackage
`default_nettype wire

// ----- rtl/fpc_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module fpc_cell #(
    parameter int FRAC_BITS = fpc_pkg::FRAC_BITS_DEF,
    parameter int CELL_ID   = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  fpc_pkg::plane_wr_t wr,
    input  fpc_pkg::probe_t    din,
    output fpc_pkg::probe_t    dout
);

    localparam int SUM_W = 66;

    logic signed [31:0] nx_reg, ny_reg, nz_reg, d_reg;
    logic signed [31:0] sx, sy, sz;
    logic signed [63:0] prod0_reg, prod1_reg, prod2_reg;
    logic signed [63:0] prod0_next, prod1_next, prod2_next;
    fpc_pkg::probe_t    a_reg;
    fpc_pkg::probe_t    dout_reg;
    fpc_pkg::probe_t    dout_next;
    logic signed [SUM_W-1:0] dist_sum, thr;
    logic               is_box;

    // plane store for this cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg <= '0;
            ny_reg <= '0;
            nz_reg <= '0;
            d_reg  <= '0;
        end
        else if (wr.en && (wr.idx == fpc_pkg::PLANE_IDX_W'(CELL_ID)))
        begin
            nx_reg <= wr.nx;
            ny_reg <= wr.ny;
            nz_reg <= wr.nz;
            d_reg  <= wr.d;
        end
    end

    // boxes take the corner picked by the normal signs
    assign is_box = (din.kind == fpc_pkg::KIND_BOX);
    assign sx = (is_box && !nx_reg[31]) ? $signed(din.x1) : $signed(din.x0);
    assign sy = (is_box && !ny_reg[31]) ? $signed(din.y1) : $signed(din.y0);
    assign sz = (is_box && !nz_reg[31]) ? $signed(din.z1) : $signed(din.z0);

    assign prod0_next = nx_reg * sx;
    assign prod1_next = ny_reg * sy;
    assign prod2_next = nz_reg * sz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg    <= '0;
            dout_reg <= '0;
        end
        else
        begin
            a_reg    <= din;
            dout_reg <= dout_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod0_reg <= prod0_next;
        prod1_reg <= prod1_next;
        prod2_reg <= prod2_next;
    end

    // distance at 2F fraction bits against 0 or -r
    assign dist_sum = SUM_W'(prod0_reg) + SUM_W'(prod1_reg) + SUM_W'(prod2_reg)
                    + (SUM_W'(d_reg) <<< FRAC_BITS);
    assign thr  = (a_reg.kind == fpc_pkg::KIND_SPHERE)
                ? -(SUM_W'($signed(a_reg.r)) <<< FRAC_BITS) : '0;

    always_comb
    begin
        dout_next      = a_reg;
        dout_next.pass = a_reg.pass & ~(dist_sum < thr);
    end

    assign dout = dout_reg;

endmodule
`default_nettype wire

// ----- rtl/fpc_extract.sv -----
`timescale 1ns / 1ps
`default_nettype none
module fpc_extract #(
    parameter int FRAC_BITS = fpc_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               ld_en,
    input  logic [1:0]         ld_col,
    input  logic [127:0]       ld_data,
    output logic               busy,
    output fpc_pkg::plane_wr_t wr
);

    localparam int DW    = 32 + FRAC_BITS;
    localparam int BCW   = $clog2(DW);
    localparam logic [5:0] PLANE_NEG = 6'b011001;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_READ   = 10'b0000000010,
        S_ELEM   = 10'b0000000100,
        S_SQ     = 10'b0000001000,
        S_ROOT   = 10'b0000010000,
        S_CHK    = 10'b0000100000,
        S_DLOAD  = 10'b0001000000,
        S_DIV    = 10'b0010000000,
        S_DSTORE = 10'b0100000000,
        S_WRITE  = 10'b1000000000
    } state_t;

    state_t state_reg;
    logic [fpc_pkg::PLANE_IDX_W-1:0] plane_reg;
    logic [1:0]  j_reg;
    logic [4:0]  it_reg;
    logic [BCW-1:0] bit_reg;
    logic signed [31:0] a_reg [4];
    logic signed [31:0] nrm_reg [4];
    logic [63:0] acc_reg, prod_reg, rad_reg;
    logic [31:0] root_reg;
    logic [33:0] rem_reg;
    logic [DW-1:0] q_reg;
    logic [31:0] drem_reg;

    logic [127:0] mat_mem [4];
    logic [127:0] rd_data_reg;
    logic [3:0]   col_vld_reg;
    logic         rd_vld_reg;

    logic signed [31:0] r3, rk;
    logic signed [32:0] esum;
    logic signed [31:0] esat;
    logic [1:0]  row;
    logic [31:0] mag_j;
    logic [35:0] rem_t, trial;
    logic [32:0] dr_t;
    logic        dge;
    logic        qbig;
    logic signed [31:0] nsat;

    // matrix columns, row 0 in the low word
    always_ff @(posedge clk)
    begin
        if (ld_en)
        begin
            mat_mem[ld_col] <= ld_data;
        end
        rd_data_reg <= mat_mem[j_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (ld_en)
            begin
                col_vld_reg[ld_col] <= 1'b1;
            end
            rd_vld_reg <= col_vld_reg[j_reg];
        end
    end

    assign row  = plane_reg[2:1];
    assign r3   = rd_vld_reg ? $signed(rd_data_reg[127:96]) : '0;
    assign rk   = rd_vld_reg ? $signed(rd_data_reg[32*row +: 32]) : '0;
    assign esum = PLANE_NEG[plane_reg] ? (33'(r3) - 33'(rk)) : (33'(r3) + 33'(rk));
    assign esat = (esum[32] != esum[31]) ? (esum[32] ? 32'sh80000000 : 32'sh7FFFFFFF)
                                         : esum[31:0];

    assign mag_j = a_reg[j_reg][31] ? 32'(-a_reg[j_reg]) : 32'(a_reg[j_reg]);

    // one root bit per step
    assign rem_t = {rem_reg, rad_reg[63:62]};
    assign trial = {2'b00, root_reg, 2'b01};

    // one quotient bit per step
    assign dr_t = {drem_reg, q_reg[DW-1]};
    assign dge  = (dr_t >= {1'b0, root_reg});

    assign qbig = |q_reg[DW-1:31];
    assign nsat = a_reg[j_reg][31]
                ? (qbig ? 32'sh80000000 : -$signed(q_reg[31:0]))
                : (qbig ? 32'sh7FFFFFFF : $signed(q_reg[31:0]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            plane_reg <= '0;
            j_reg     <= '0;
            it_reg    <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (ld_en && (ld_col == 2'd3))
                    begin
                        plane_reg <= '0;
                        j_reg     <= '0;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_ELEM;
                end
                S_ELEM:
                begin
                    j_reg <= j_reg + 2'd1;
                    state_reg <= (j_reg == 2'd3) ? S_SQ : S_READ;
                end
                S_SQ:
                begin
                    j_reg <= j_reg + 2'd1;
                    if (j_reg == 2'd3)
                    begin
                        it_reg    <= '0;
                        state_reg <= S_ROOT;
                    end
                end
                S_ROOT:
                begin
                    it_reg <= it_reg + 5'd1;
                    if (it_reg == 5'd31)
                    begin
                        state_reg <= S_CHK;
                    end
                end
                S_CHK:
                begin
                    j_reg     <= '0;
                    state_reg <= (root_reg == '0) ? S_WRITE : S_DLOAD;
                end
                S_DLOAD:
                begin
                    bit_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    bit_reg <= bit_reg + BCW'(1);
                    if (bit_reg == BCW'(DW - 1))
                    begin
                        state_reg <= S_DSTORE;
                    end
                end
                S_DSTORE:
                begin
                    j_reg     <= j_reg + 2'd1;
                    state_reg <= (j_reg == 2'd3) ? S_WRITE : S_DLOAD;
                end
                S_WRITE:
                begin
                    j_reg     <= '0;
                    plane_reg <= plane_reg + 3'd1;
                    state_reg <= (plane_reg == 3'(fpc_pkg::NUM_PLANES - 1)) ? S_IDLE : S_READ;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_ELEM:
            begin
                a_reg[j_reg] <= esat;
                acc_reg      <= '0;
            end
            S_SQ:
            begin
                prod_reg <= 64'(mag_j) * 64'(mag_j);
                if (j_reg != 2'd0)
                begin
                    acc_reg <= acc_reg + prod_reg;
                end
                if (j_reg == 2'd3)
                begin
                    rad_reg  <= acc_reg + prod_reg;
                    rem_reg  <= '0;
                    root_reg <= '0;
                end
            end
            S_ROOT:
            begin
                rad_reg <= {rad_reg[61:0], 2'b00};
                if (rem_t >= trial)
                begin
                    rem_reg  <= 34'(rem_t - trial);
                    root_reg <= {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_t[33:0];
                    root_reg <= {root_reg[30:0], 1'b0};
                end
            end
            S_CHK:
            begin
                if (root_reg == '0)
                begin
                    nrm_reg[0] <= '0;
                    nrm_reg[1] <= '0;
                    nrm_reg[2] <= '0;
                    nrm_reg[3] <= '0;
                end
            end
            S_DLOAD:
            begin
                q_reg    <= {mag_j, {FRAC_BITS{1'b0}}};
                drem_reg <= '0;
            end
            S_DIV:
            begin
                drem_reg <= dge ? 32'(dr_t - {1'b0, root_reg}) : dr_t[31:0];
                q_reg    <= {q_reg[DW-2:0], dge};
            end
            S_DSTORE:
            begin
                nrm_reg[j_reg] <= nsat;
            end
            default:
            begin
            end
        endcase
    end

    assign busy   = (state_reg != S_IDLE);
    assign wr.en  = (state_reg == S_WRITE);
    assign wr.idx = plane_reg;
    assign wr.nx  = nrm_reg[0];
    assign wr.ny  = nrm_reg[1];
    assign wr.nz  = nrm_reg[2];
    assign wr.d   = nrm_reg[3];

endmodule
`default_nettype wire

// ----- rtl/frustum_plane_cull.sv -----
`timescale 1ns / 1ps
`default_nettype none
// View-frustum culler on six normalised planes, Q(32-F).F throughout.
// Input stream s_*: one beat is a column load (kind 0) or a point, sphere or
// box test (kinds 1 to 3). Output stream m_*: one beat per test, bit 0 set when
// the object is inside or touching the frustum, clear when some plane culls it.
// Tests run down a chain of six plane cells, two register stages per cell
// (products, then sum and compare), and then into the output register, one
// test in flight at a time. Loading column 3 starts plane extraction
// (saturating row sums and differences, squares through one multiplier, a
// 32-step bit-serial square root, four (32+F)-step bit-serial divides per
// plane unless its norm is zero); s_tready stays low for all of it.
// After reset the matrix and all planes read as zero, so every test passes,
// save a sphere of negative radius. A stalled receiver does not hold up the
// chain: a finished result waits in the output register, a second one in a
// skid register, and s_tready also drops while the skid register is full.
module frustum_plane_cull #(
    parameter int FRAC_BITS = fpc_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [223:0] s_tdata,  // v0, v1, v2, v3, w0, w1, w2 (32 bits each)
    input  logic [3:0]   s_tuser,  // kind [1:0], column [3:2]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata   // inside_res [0], zero fill [7:1]
);

    localparam int NP = fpc_pkg::NUM_PLANES;

    fpc_pkg::kind_t     kind;
    logic               accept;
    logic               ld_en;
    logic               ext_busy;
    fpc_pkg::plane_wr_t pwr;
    fpc_pkg::probe_t    link [NP+1];
    logic [NP:0]        chain_vld;
    logic               test_busy_reg;
    logic               out_v_reg, skid_v_reg;
    logic               out_reg, skid_reg;
    logic               res_v, res;

    assign kind     = fpc_pkg::kind_t'(s_tuser[1:0]);
    assign s_tready = !ext_busy && !test_busy_reg && !skid_v_reg;
    assign accept   = s_tvalid && s_tready;
    assign ld_en    = accept && (kind == fpc_pkg::KIND_LOAD);

    fpc_extract #(
        .FRAC_BITS(FRAC_BITS)
    ) u_extract (
        .clk    (clk),
        .rst_n  (rst_n),
        .ld_en  (ld_en),
        .ld_col (s_tuser[3:2]),
        .ld_data(s_tdata[127:0]),
        .busy   (ext_busy),
        .wr     (pwr)
    );

    // test beat enters the head of the chain
    always_comb
    begin
        link[0].valid = accept && (kind != fpc_pkg::KIND_LOAD);
        link[0].pass  = 1'b1;
        link[0].kind  = kind;
        link[0].x0    = s_tdata[31:0];
        link[0].y0    = s_tdata[63:32];
        link[0].z0    = s_tdata[95:64];
        link[0].r     = s_tdata[127:96];
        link[0].x1    = s_tdata[159:128];
        link[0].y1    = s_tdata[191:160];
        link[0].z1    = s_tdata[223:192];
    end

    for (genvar g = 0; g < NP; g++)
    begin : g_cell
        fpc_cell #(
            .FRAC_BITS(FRAC_BITS),
            .CELL_ID  (g)
        ) u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .wr   (pwr),
            .din  (link[g]),
            .dout (link[g+1])
        );
    end

    for (genvar k = 0; k <= NP; k++)
    begin : g_vld
        assign chain_vld[k] = link[k].valid;
    end

    assign res_v = link[NP].valid;
    assign res   = link[NP].pass;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            test_busy_reg <= 1'b0;
            out_v_reg     <= 1'b0;
            skid_v_reg    <= 1'b0;
        end
        else
        begin
            if (link[0].valid)
            begin
                test_busy_reg <= 1'b1;
            end
            else if (res_v)
            begin
                test_busy_reg <= 1'b0;
            end

            if (!out_v_reg || m_tready)
            begin
                if (skid_v_reg)
                begin
                    out_v_reg  <= 1'b1;
                    skid_v_reg <= 1'b0;
                end
                else
                begin
                    out_v_reg <= res_v;
                end
            end
            else if (res_v)
            begin
                skid_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_v_reg || m_tready)
        begin
            out_reg <= skid_v_reg ? skid_reg : res;
        end
        else if (res_v)
        begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {7'd0, out_reg};

    // a result never lands on a full skid register
    assert property (@(posedge clk) disable iff (!rst_n) res_v |-> !skid_v_reg)
        else $error("result arrived with skid register full");

    // extraction and tests never overlap
    assert property (@(posedge clk) disable iff (!rst_n) ext_busy |-> !test_busy_reg)
        else $error("test in flight during plane extraction");

    // at most one test beat in the chain
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(chain_vld))
        else $error("more than one test beat in the chain");

    // a test entering the chain leaves it after two stages per cell
    assert property (@(posedge clk) disable iff (!rst_n)
        link[0].valid |-> ##(2 * NP) res_v)
        else $error("test beat lost in the chain");

endmodule
`default_nettype wire
